### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. They expect i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every clock edge out of reset.
`define L2H_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

// Same-cycle implication.
`define L2H_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define L2H_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/l2hist_pkg.sv
// ----------------------------------------------------------------------------
// l2hist_pkg
// Types, constants and helpers for the log2 latency histogram.
// ----------------------------------------------------------------------------
package l2hist_pkg;

    localparam int NUM_BUCKETS = 48;
    localparam int COUNT_WIDTH = 32;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);

    localparam int LAT_W  = 64;
    localparam int POS_W  = $clog2(LAT_W);
    localparam int PM_W   = 10;
    localparam int PM_MAX = 1000;
    localparam int SEL_W  = 6;
    localparam int RES_W  = 48;
    localparam int TOT_W  = 32;

    // total * permille, bucket count * 1000, and the scaled running sum
    localparam int PROD_W = COUNT_WIDTH + PM_W;
    localparam int SUM_W  = COUNT_WIDTH + BKT_W + PM_W;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_PCTL   = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REC_WR,
        ST_RD_OUT,
        ST_Q_MUL,
        ST_Q_SCL,
        ST_Q_ACC
    } t_state;

    typedef struct packed {
        logic [1:0]       op;
        logic [LAT_W-1:0] latency;
        logic [PM_W-1:0]  permille;
        logic [SEL_W-1:0] bucket_sel;
    } t_cmd;

    typedef struct packed {
        logic [RES_W-1:0] result_value;
        logic [SEL_W-1:0] found_bucket;
        logic [TOT_W-1:0] sample_total;
    } t_rsp;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // bucket i spans [2^i, 2^(i+1)); midpoint 1 for i = 0, else 3*2^(i-1)
    function automatic logic [RES_W-1:0] midpoint(input logic [BKT_W-1:0] i);
        if (i == '0) begin
            return RES_W'(1);
        end else begin
            return RES_W'(3) << (i - BKT_W'(1));
        end
    endfunction

endpackage

### rtl/log2_latency_histogram.sv
// ----------------------------------------------------------------------------
// log2_latency_histogram
// Power-of-two latency histogram with percentile and bucket-read queries.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat (i_cmd) is taken at a rising edge where start is
//   high and busy is low. op selects record, percentile query or bucket read;
//   the unused op code is taken and dropped.
//   Result channel: o_valid strobes for one cycle with o_rsp. The receiver
//   cannot stall; results are never held.
//   Sequence per op, from the accept edge:
//     record      busy in ST_REC_WR (one read-modify-write of the count RAM);
//                 the next beat is taken only after that; no result.
//     bucket read busy in ST_RD_OUT; o_valid is registered out of that state.
//     percentile  busy through ST_Q_MUL (total * permille), then per bucket
//                 walked (1..NUM_BUCKETS) ST_Q_SCL scales the count by 1000
//                 and ST_Q_ACC adds and compares. o_valid follows.
//   The next beat may be given in the cycle o_valid is high.
//   Reset (synchronous, active low) zeroes the sample total and the per-entry
//   valid bits, so all bucket counts read as zero at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module log2_latency_histogram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  l2hist_pkg::t_cmd   i_cmd,
    output logic               o_valid,
    output l2hist_pkg::t_rsp   o_rsp
);

    localparam int NB    = l2hist_pkg::NUM_BUCKETS;
    localparam int CW    = l2hist_pkg::COUNT_WIDTH;
    localparam int BKT_W = l2hist_pkg::BKT_W;
    localparam int SEL_W = l2hist_pkg::SEL_W;
    localparam int POS_W = l2hist_pkg::POS_W;

    // Count RAM: one sync read port, one write port
    logic [CW-1:0]    mem_bucket [NB];
    logic [CW-1:0]    r_rdata;
    logic             r_rd_vld;
    logic [NB-1:0]    r_vld;          // entry written since reset

    l2hist_pkg::t_state r_state, n_state;

    logic [BKT_W-1:0]              r_idx, n_idx;
    logic [SEL_W-1:0]              r_sel, n_sel;
    logic                          r_sel_ok, n_sel_ok;
    logic [l2hist_pkg::PM_W-1:0]   r_pm, n_pm;
    logic [CW-1:0]                 r_total, n_total;
    logic [l2hist_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [l2hist_pkg::PROD_W-1:0] r_scaled, n_scaled;
    logic [l2hist_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic                          r_out_vld, n_out_vld;
    l2hist_pkg::t_rsp              r_out, n_out;

    logic [BKT_W-1:0]              rd_addr;
    logic                          mem_we;
    logic [CW-1:0]                 cnt;
    logic [POS_W-1:0]              top_pos;
    logic [BKT_W-1:0]              rec_idx;
    logic [l2hist_pkg::SUM_W-1:0]  acc_sum;
    logic                          sel_in_range;

    assign busy    = (r_state != l2hist_pkg::ST_IDLE);
    assign o_valid = r_out_vld;
    assign o_rsp   = r_out;

    // never-written entries read as zero
    assign cnt = r_rd_vld ? r_rdata : '0;

    // top set bit of latency; zero treated as one, so bit 0 is the floor
    always_comb begin
        top_pos = '0;
        for (int b = 0; b < l2hist_pkg::LAT_W; b++) begin
            if (i_cmd.latency[b]) begin
                top_pos = POS_W'(b);
            end
        end
    end

    // positions past the last bucket land in the last bucket
    assign rec_idx = (top_pos > POS_W'(NB - 1)) ? BKT_W'(NB - 1) : BKT_W'(top_pos);

    assign sel_in_range = ({1'b0, i_cmd.bucket_sel} < (SEL_W + 1)'(NB));

    // running sum is kept as (cum + 1) * 1000, compared with total * permille:
    // cum >= floor(total*pm/1000)  <=>  (cum + 1) * 1000 > total * pm
    assign acc_sum = r_sum + l2hist_pkg::SUM_W'(r_scaled);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_sel     = r_sel;
        n_sel_ok  = r_sel_ok;
        n_pm      = r_pm;
        n_total   = r_total;
        n_prod    = r_prod;
        n_scaled  = r_scaled;
        n_sum     = r_sum;
        n_out_vld = 1'b0;
        n_out     = r_out;
        rd_addr   = '0;
        mem_we    = 1'b0;

        unique case (r_state)
            l2hist_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (i_cmd.op)
                        l2hist_pkg::OP_RECORD: begin
                            n_idx   = rec_idx;
                            rd_addr = rec_idx;
                            n_state = l2hist_pkg::ST_REC_WR;
                        end
                        l2hist_pkg::OP_PCTL: begin
                            n_pm    = (i_cmd.permille > l2hist_pkg::PM_W'(l2hist_pkg::PM_MAX))
                                      ? l2hist_pkg::PM_W'(l2hist_pkg::PM_MAX)
                                      : i_cmd.permille;
                            n_idx   = '0;
                            n_state = l2hist_pkg::ST_Q_MUL;
                        end
                        l2hist_pkg::OP_READ: begin
                            n_sel    = i_cmd.bucket_sel;
                            n_sel_ok = sel_in_range;
                            rd_addr  = sel_in_range ? BKT_W'(i_cmd.bucket_sel) : '0;
                            n_state  = l2hist_pkg::ST_RD_OUT;
                        end
                        default: begin
                            // unused op: dropped
                        end
                    endcase
                end
            end
            l2hist_pkg::ST_REC_WR: begin
                mem_we  = 1'b1;
                n_total = l2hist_pkg::sat_inc(r_total);
                n_state = l2hist_pkg::ST_IDLE;
            end
            l2hist_pkg::ST_RD_OUT: begin
                n_out_vld          = 1'b1;
                n_out.result_value = r_sel_ok ? l2hist_pkg::RES_W'(cnt) : '0;
                n_out.found_bucket = r_sel;
                n_out.sample_total = l2hist_pkg::TOT_W'(r_total);
                n_state            = l2hist_pkg::ST_IDLE;
            end
            l2hist_pkg::ST_Q_MUL: begin
                n_prod  = l2hist_pkg::PROD_W'(r_total) * l2hist_pkg::PROD_W'(r_pm);
                n_sum   = l2hist_pkg::SUM_W'(l2hist_pkg::PM_MAX);
                rd_addr = '0;
                n_state = l2hist_pkg::ST_Q_SCL;
            end
            l2hist_pkg::ST_Q_SCL: begin
                n_scaled = l2hist_pkg::PROD_W'(cnt)
                           * l2hist_pkg::PROD_W'(l2hist_pkg::PM_MAX);
                n_state  = l2hist_pkg::ST_Q_ACC;
            end
            l2hist_pkg::ST_Q_ACC: begin
                n_sum = acc_sum;
                if (acc_sum > l2hist_pkg::SUM_W'(r_prod)) begin
                    n_out_vld          = 1'b1;
                    n_out.result_value = l2hist_pkg::midpoint(r_idx);
                    n_out.found_bucket = SEL_W'(r_idx);
                    n_out.sample_total = l2hist_pkg::TOT_W'(r_total);
                    n_state            = l2hist_pkg::ST_IDLE;
                end else if (r_idx == BKT_W'(NB - 1)) begin
                    // target never reached
                    n_out_vld          = 1'b1;
                    n_out.result_value = '0;
                    n_out.found_bucket = '0;
                    n_out.sample_total = l2hist_pkg::TOT_W'(r_total);
                    n_state            = l2hist_pkg::ST_IDLE;
                end else begin
                    n_idx   = r_idx + BKT_W'(1);
                    rd_addr = r_idx + BKT_W'(1);
                    n_state = l2hist_pkg::ST_Q_SCL;
                end
            end
            default: begin
                n_state = l2hist_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= l2hist_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
            r_total   <= '0;
            r_vld     <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_total   <= n_total;
            if (mem_we) begin
                r_vld[r_idx] <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_sel    <= n_sel;
        r_sel_ok <= n_sel_ok;
        r_pm     <= n_pm;
        r_prod   <= n_prod;
        r_scaled <= n_scaled;
        r_sum    <= n_sum;
        r_out    <= n_out;
    end

    // count RAM; a write can hit entry 0 while the idle read port also reads it
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_bucket[r_idx] <= l2hist_pkg::sat_inc(cnt);
        end
        r_rdata  <= mem_bucket[rd_addr];
        r_rd_vld <= r_vld[rd_addr];
    end

    `L2H_ASSERT_NXT(a_strobe_single, o_valid, !o_valid)
    `L2H_ASSERT_NXT(a_record_silent, r_state == l2hist_pkg::ST_REC_WR, !o_valid)
    `L2H_ASSERT_IMP(a_idx_range, busy, r_idx < BKT_W'(NB - 1) || r_idx == BKT_W'(NB - 1))
    `L2H_ASSERT_IMP(a_total_mono, $past(i_rst_n), r_total >= $past(r_total))

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for log2_latency_histogram: drives record, percentile
// and bucket-read commands, predicts each response with a local histogram
// model and compares the response fields in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int NUM_BUCKETS = l2hist_pkg::NUM_BUCKETS;
    localparam int COUNT_WIDTH = l2hist_pkg::COUNT_WIDTH;
    localparam int LAT_W       = l2hist_pkg::LAT_W;
    localparam int PM_W        = l2hist_pkg::PM_W;
    localparam int PM_MAX      = l2hist_pkg::PM_MAX;
    localparam int SEL_W       = l2hist_pkg::SEL_W;
    localparam int RES_W       = l2hist_pkg::RES_W;
    localparam int TOT_W       = l2hist_pkg::TOT_W;

    // op code the block takes and drops
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // random stimulus split: with gaps first, then back to back
    localparam int RAND_GAPPED  = 450;
    localparam int RAND_DENSE   = 100;
    // drain allowance: covers the longest query, a walk over all NUM_BUCKETS buckets
    localparam int DRAIN_CYCLES = 4 * NUM_BUCKETS + 20;
    localparam int DRAIN_LIMIT  = 4000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    l2hist_pkg::t_cmd   cmd_bus;
    logic               o_valid;
    l2hist_pkg::t_rsp   o_rsp;

    // local copy of the histogram state
    logic [COUNT_WIDTH-1:0] hist_counts [NUM_BUCKETS];
    logic [COUNT_WIDTH-1:0] hist_total;

    // responses still owed by the block, oldest first
    l2hist_pkg::t_rsp rsp_expected [$];
    int               mismatch_count;

    log2_latency_histogram dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd_bus),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // append to the tail of the owed-response queue
    task automatic owe_rsp(input l2hist_pkg::t_rsp r);
        rsp_expected.insert(rsp_expected.size(), r);
    endtask

    // ------------------------------------------------------------------------
    // Histogram model. Runs once per accepted beat and queues the response
    // that beat owes, if any.
    // ------------------------------------------------------------------------
    task automatic predict_histogram(input l2hist_pkg::t_cmd c);
        logic [LAT_W-1:0] lat_or1;
        int unsigned      bkt;
        logic [PM_W-1:0]  pm;
        logic [63:0]      goal;
        logic [63:0]      running;
        bit               reached;
        l2hist_pkg::t_rsp r;
        r = '0;
        case (c.op)
            l2hist_pkg::OP_RECORD: begin
                // zero counts as one, so it lands in bucket 0
                lat_or1 = c.latency | 64'd1;
                bkt = 0;
                for (int b = 0; b < LAT_W; b++) begin
                    if (lat_or1[b]) bkt = b;
                end
                if (bkt >= NUM_BUCKETS) bkt = NUM_BUCKETS - 1;
                if (hist_counts[bkt] != '1) hist_counts[bkt] = hist_counts[bkt] + 1'b1;
                if (hist_total != '1) hist_total = hist_total + 1'b1;
            end
            l2hist_pkg::OP_PCTL: begin
                pm = (c.permille > PM_W'(PM_MAX)) ? PM_W'(PM_MAX) : c.permille;
                // exact floor of total * permille / 1000
                goal = (64'(hist_total) * 64'(pm)) / 64'd1000;
                running = '0;
                reached = 1'b0;
                for (int i = 0; i < NUM_BUCKETS; i++) begin
                    if (!reached) begin
                        running = running + 64'(hist_counts[i]);
                        if (running >= goal) begin
                            reached = 1'b1;
                            r.found_bucket = SEL_W'(i);
                            r.result_value = (i == 0) ? RES_W'(1) : (RES_W'(3) << (i - 1));
                        end
                    end
                end
                r.sample_total = TOT_W'(hist_total);
                owe_rsp(r);
            end
            l2hist_pkg::OP_READ: begin
                if (c.bucket_sel < NUM_BUCKETS) begin
                    r.result_value = RES_W'(hist_counts[c.bucket_sel]);
                end
                r.found_bucket = c.bucket_sel;
                r.sample_total = TOT_W'(hist_total);
                owe_rsp(r);
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Command side. A beat is driven at the falling edge and held until a
    // rising edge sees busy low. start stays high when beats follow back to
    // back; idle_gap lowers it, as does the sequencer at the end.
    // ------------------------------------------------------------------------
    task automatic send_cmd(input l2hist_pkg::t_cmd c);
        @(negedge i_clk);
        start   <= 1'b1;
        cmd_bus <= c;
        do @(posedge i_clk); while (busy);
        predict_histogram(c);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(1, 17);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // op from the caller, every other field random; the caller then forces the field it cares about
    function automatic l2hist_pkg::t_cmd noisy_cmd(input logic [1:0] op);
        l2hist_pkg::t_cmd c;
        c.op         = op;
        c.latency    = {$urandom, $urandom};
        c.permille   = PM_W'($urandom);
        c.bucket_sel = SEL_W'($urandom);
        return c;
    endfunction

    // spread latencies over all top-bit positions, not just the upper ones
    function automatic logic [LAT_W-1:0] random_latency();
        logic [LAT_W-1:0] v;
        v = {$urandom, $urandom};
        return v >> $urandom_range(0, LAT_W - 1);
    endfunction

    task automatic do_record(input logic [LAT_W-1:0] lat);
        l2hist_pkg::t_cmd c;
        c = noisy_cmd(l2hist_pkg::OP_RECORD);
        c.latency = lat;
        send_cmd(c);
    endtask

    task automatic do_query(input logic [PM_W-1:0] pm);
        l2hist_pkg::t_cmd c;
        c = noisy_cmd(l2hist_pkg::OP_PCTL);
        c.permille = pm;
        send_cmd(c);
    endtask

    task automatic do_read(input logic [SEL_W-1:0] sel);
        l2hist_pkg::t_cmd c;
        c = noisy_cmd(l2hist_pkg::OP_READ);
        c.bucket_sel = sel;
        send_cmd(c);
    endtask

    // ------------------------------------------------------------------------
    // Response side. The block cannot be stalled, so every strobe is a beat.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        l2hist_pkg::t_rsp want;
        if (i_rst_n && o_valid) begin
            if (rsp_expected.size() == 0) begin
                report_error($sformatf("unexpected response value=%0h bucket=%0d",
                                       o_rsp.result_value, o_rsp.found_bucket));
            end else begin
                want = rsp_expected.pop_front();
                if (o_rsp.result_value !== want.result_value)
                    report_error($sformatf("result_value %0h, expected %0h",
                                           o_rsp.result_value, want.result_value));
                if (o_rsp.found_bucket !== want.found_bucket)
                    report_error($sformatf("found_bucket %0d, expected %0d",
                                           o_rsp.found_bucket, want.found_bucket));
                if (o_rsp.sample_total !== want.sample_total)
                    report_error($sformatf("sample_total %0d, expected %0d",
                                           o_rsp.sample_total, want.sample_total));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // nothing recorded yet: target is zero, bucket 0 is hit at once
    task automatic test_empty_histogram();
        do_query(PM_W'(500));
        do_read(SEL_W'(0));
    endtask

    // zero and one share bucket 0; top bits at and past the last bucket clamp
    task automatic test_record_extremes();
        do_record(64'd0);
        do_record(64'd1);
        do_record(64'd2);
        do_record(64'd3);
        do_record(64'hFFFF_FFFF_FFFF_FFFF);
        do_record(64'd1 << 46);
        do_record(64'd1 << 47);
        do_record(64'd1 << 48);
    endtask

    // lowest, highest and over-range permille (above 1000 acts as 1000)
    task automatic test_percentile_edges();
        do_query(PM_W'(0));
        do_query(PM_W'(1));
        do_query(PM_W'(999));
        do_query(PM_W'(PM_MAX));
        do_query(PM_W'(1023));
    endtask

    // first and last bucket, then selects past the last bucket read as zero
    task automatic test_bucket_reads();
        do_read(SEL_W'(0));
        do_read(SEL_W'(1));
        do_read(SEL_W'(NUM_BUCKETS - 1));
        do_read(SEL_W'(NUM_BUCKETS));
        do_read(SEL_W'(63));
    endtask

    // unused op: taken, no state change, no response; the read confirms it
    task automatic test_unused_op();
        l2hist_pkg::t_cmd c;
        c = '1;
        c.op = OP_UNUSED;
        send_cmd(c);
        do_read(SEL_W'(NUM_BUCKETS - 1));
    endtask

    // mostly records so the percentile walk sees a populated histogram;
    // gaps come in bursts so they land on every phase of a query walk
    task automatic test_random_mix(input int n_items, input bit with_gaps);
        int  sent;
        int  pick;
        bit  gap_phase;
        l2hist_pkg::t_cmd c;
        sent = 0;
        gap_phase = 1'b1;
        while (sent < n_items) begin
            if (with_gaps && ($urandom_range(0, 29) == 0)) gap_phase = !gap_phase;
            if (with_gaps && gap_phase && ($urandom_range(0, 3) == 0)) idle_gap();
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                do_record(random_latency());
                sent++;
            end else if (pick < 84) begin
                if ($urandom_range(0, 9) == 0)
                    do_query(PM_W'($urandom_range(PM_MAX + 1, 1023)));
                else
                    do_query(PM_W'($urandom_range(0, PM_MAX)));
                sent++;
            end else if (pick < 97) begin
                do_read(SEL_W'($urandom_range(0, 63)));
                sent++;
            end else begin
                // dropped by the block, not counted as an item
                c = noisy_cmd(OP_UNUSED);
                send_cmd(c);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial begin
        int waited;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        cmd_bus        = '0;
        hist_total     = '0;
        mismatch_count = 0;
        for (int i = 0; i < NUM_BUCKETS; i++) hist_counts[i] = '0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_histogram();
        test_record_extremes();
        test_percentile_edges();
        test_bucket_reads();
        test_unused_op();
        test_random_mix(RAND_GAPPED, 1'b1);
        test_random_mix(RAND_DENSE, 1'b0);

        @(negedge i_clk);
        start <= 1'b0;

        // drain: wait for owed responses, bounded, then a latency's worth more
        waited = 0;
        while (rsp_expected.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (rsp_expected.size() != 0)
            report_error($sformatf("%0d responses never arrived", rsp_expected.size()));

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog: far above the slowest legal run
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
